/* src/lcd4_pkg.sv */
package lcd4_pkg;

	// sequencer phases
	typedef enum logic [2:0] {
		PH_POWER,
		PH_NIB_PRE,
		PH_NIB_HIGH,
		PH_NIB_POST,
		PH_WAIT,
		PH_IDLE,
		PH_POLL
	} phase_t;

	localparam logic [2:0] STEPS_DONE = 3'd6;

	// request opcodes
	localparam logic [2:0] OP_DATA     = 3'd0;
	localparam logic [2:0] OP_COMMAND  = 3'd1;
	localparam logic [2:0] OP_CLEAR    = 3'd2;
	localparam logic [2:0] OP_HOME     = 3'd3;
	localparam logic [2:0] OP_CURSOR   = 3'd4;
	localparam logic [2:0] OP_POSITION = 3'd5;

	// register indexes
	localparam logic [2:0] CFG_CYCLES_PER_US = 3'd0;
	localparam logic [2:0] CFG_ENABLE_PHASE  = 3'd1;
	localparam logic [2:0] CFG_SETTLE        = 3'd2;
	localparam logic [2:0] CFG_POWER_ON      = 3'd3;
	localparam logic [2:0] CFG_MODE_SWITCH   = 3'd4;

	// register reset values
	localparam logic [7:0]  RST_CYCLES_PER_US = 8'd50;
	localparam logic [9:0]  RST_ENABLE_PHASE  = 10'd100;
	localparam logic [13:0] RST_SETTLE        = 14'd150;
	localparam logic [15:0] RST_POWER_ON      = 16'd40000;
	localparam logic [15:0] RST_MODE_SWITCH   = 16'd4500;

	// lcd instruction bytes
	localparam logic [7:0] CMD_CLEAR       = 8'h01;
	localparam logic [7:0] CMD_HOME        = 8'h02;
	localparam logic [7:0] CMD_CURSOR_BASE = 8'h0C;
	localparam logic [7:0] CMD_SET_ADDR    = 8'h80;
	localparam logic [7:0] CMD_FUNC_4BIT   = 8'h28;
	localparam logic [7:0] CMD_DISPLAY_ON  = 8'h0E;
	localparam logic [7:0] CMD_ENTRY_MODE  = 8'h06;

	// stream widths
	localparam int S_TDATA_W = 24;
	localparam int S_TUSER_W = 4;
	localparam int M_TDATA_W = 16;
	localparam int CFG_DATA_W = 16;

	// queue between front and back
	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_AW    = 2;
	localparam int QUEUE_CW    = 3;

	// classified request plus the sampled busy level
	typedef struct packed {
		logic       go;
		logic       is_data;
		logic [7:0] cmd_byte;
		logic       busy;
	} item_t;

	// pin levels, register_select in the lowest bit
	typedef struct packed {
		logic       init_done;
		logic       ready_res;
		logic       top_line_input;
		logic [3:0] data_nibble;
		logic       enable_pin;
		logic       read_write;
		logic       register_select;
	} pins_t;

	localparam int PINS_PAD_W = M_TDATA_W - $bits(pins_t);

	typedef struct packed {
		logic [7:0]  cycles_per_us;
		logic [9:0]  enable_phase_us;
		logic [13:0] settle_us;
		logic [15:0] power_on_us;
		logic [15:0] mode_switch_us;
	} cfg_t;

	// power-on byte sequence, the first entry is the lone mode nibble
	function automatic logic [7:0] init_byte(input logic [2:0] step);
		logic [7:0] b;
		unique case (step)
			3'd0:    b = CMD_HOME;
			3'd1:    b = CMD_FUNC_4BIT;
			3'd2:    b = CMD_FUNC_4BIT;
			3'd3:    b = CMD_DISPLAY_ON;
			3'd4:    b = CMD_CLEAR;
			3'd5:    b = CMD_ENTRY_MODE;
			default: b = CMD_ENTRY_MODE;
		endcase
		return b;
	endfunction

endpackage

/* src/lcd_4bit_interface_sequencer.sv */
// path: a transaction taken on the slave side is held in the queue and then in the output register
//   before its result shows on the master side
// throughput: one transaction per cycle while the master side takes each result, one sequencer step each
// reset: arst_n low clears the control state at once; the sequencer restarts with the power-on wait,
//   the configuration registers return to their defaults and the queue empties (its storage is not cleared)
module lcd_4bit_interface_sequencer #(
	parameter int DELAY_COUNT_WIDTH = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// slave side: one transaction per pin-timing cycle
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	// byte_value[7:0], row_index[9:8], column_index[15:10], cursor_show[16],
	// cursor_blink[17], busy_line[18], zero[23:19]
	input  logic [lcd4_pkg::S_TDATA_W-1:0]  s_axis_tdata,
	// request_valid[0], opcode[3:1]
	input  logic [lcd4_pkg::S_TUSER_W-1:0]  s_axis_tuser,
	// master side: pin levels for that cycle
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	// register_select[0], read_write[1], enable_pin[2], data_nibble[6:3],
	// top_line_input[7], ready_res[8], init_done[9], zero[15:10]
	output logic [lcd4_pkg::M_TDATA_W-1:0]  m_axis_tdata,
	// configuration write channel
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [2:0]                      cfg_index,
	input  logic [lcd4_pkg::CFG_DATA_W-1:0] cfg_data
);

	lcd4_pkg::item_t front_item;
	lcd4_pkg::item_t queue_item;
	logic            queue_valid;
	logic            queue_ready;

	// registers are always writable; writes land in the back end directly
	assign cfg_ready = 1'b1;

	// front end: unpack the transaction and turn the opcode into the byte to send
	lcd4_front u_front (
		.s_tdata (s_axis_tdata),
		.s_tuser (s_axis_tuser),
		.item    (front_item)
	);

	// short queue so the slave side keeps flowing while the master side stalls
	lcd4_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (s_axis_tvalid),
		.push_ready (s_axis_tready),
		.push_item  (front_item),
		.pop_valid  (queue_valid),
		.pop_ready  (queue_ready),
		.pop_item   (queue_item)
	);

	// back end: power-on sequence, busy poll, nibble strobes and delay timer
	lcd4_back #(
		.DELAY_COUNT_WIDTH (DELAY_COUNT_WIDTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr    (cfg_valid && cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.q_valid   (queue_valid),
		.q_ready   (queue_ready),
		.q_item    (queue_item),
		.m_tvalid  (m_axis_tvalid),
		.m_tready  (m_axis_tready),
		.m_tdata   (m_axis_tdata)
	);

endmodule

/* src/lcd4_front.sv */
module lcd4_front (
	input  logic [lcd4_pkg::S_TDATA_W-1:0] s_tdata,
	input  logic [lcd4_pkg::S_TUSER_W-1:0] s_tuser,
	output lcd4_pkg::item_t                item
);

	logic       req_valid;
	logic [2:0] opcode;
	logic [7:0] byte_value;
	logic [1:0] row_index;
	logic [5:0] column_index;
	logic       cursor_show;
	logic       cursor_blink;

	assign req_valid    = s_tuser[0];
	assign opcode       = s_tuser[3:1];
	assign byte_value   = s_tdata[7:0];
	assign row_index    = s_tdata[9:8];
	assign column_index = s_tdata[15:10];
	assign cursor_show  = s_tdata[16];
	assign cursor_blink = s_tdata[17];

	always_comb begin
		item.go       = 1'b0;
		item.is_data  = 1'b0;
		item.cmd_byte = byte_value;
		item.busy     = s_tdata[18];
		unique case (opcode)
			lcd4_pkg::OP_DATA: begin
				item.go      = req_valid;
				item.is_data = 1'b1;
			end
			lcd4_pkg::OP_COMMAND: begin
				item.go = req_valid;
			end
			lcd4_pkg::OP_CLEAR: begin
				item.go       = req_valid;
				item.cmd_byte = lcd4_pkg::CMD_CLEAR;
			end
			lcd4_pkg::OP_HOME: begin
				item.go       = req_valid;
				item.cmd_byte = lcd4_pkg::CMD_HOME;
			end
			lcd4_pkg::OP_CURSOR: begin
				item.go       = req_valid;
				item.cmd_byte = lcd4_pkg::CMD_CURSOR_BASE | {6'd0, cursor_show, cursor_blink};
			end
			lcd4_pkg::OP_POSITION: begin
				// two rows of sixteen columns only
				item.go       = req_valid && !row_index[1] && (column_index[5:4] == 2'd0);
				item.cmd_byte = lcd4_pkg::CMD_SET_ADDR | {1'b0, row_index[0], 2'b00,
					column_index[3:0]};
			end
			default: begin
				item.go = 1'b0;
			end
		endcase
	end

endmodule

/* src/lcd4_fifo.sv */
module lcd4_fifo (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push_valid,
	output logic            push_ready,
	input  lcd4_pkg::item_t push_item,
	output logic            pop_valid,
	input  logic            pop_ready,
	output lcd4_pkg::item_t pop_item
);

	lcd4_pkg::item_t                 mem_q [lcd4_pkg::QUEUE_DEPTH];
	logic [lcd4_pkg::QUEUE_AW-1:0]   wr_ptr_q;
	logic [lcd4_pkg::QUEUE_AW-1:0]   rd_ptr_q;
	logic [lcd4_pkg::QUEUE_CW-1:0]   count_q;
	logic                            push;
	logic                            pop;

	assign push_ready = (count_q != lcd4_pkg::QUEUE_CW'(lcd4_pkg::QUEUE_DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_item   = mem_q[rd_ptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

/* src/lcd4_back.sv */
module lcd4_back #(
	parameter int DELAY_COUNT_WIDTH = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_wr,
	input  logic [2:0]                      cfg_index,
	input  logic [lcd4_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                            q_valid,
	output logic                            q_ready,
	input  lcd4_pkg::item_t                 q_item,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [lcd4_pkg::M_TDATA_W-1:0]  m_tdata
);

	lcd4_pkg::cfg_t              cfg_q;
	lcd4_pkg::phase_t            phase_q, phase_d;
	logic [2:0]                  step_q, step_d;
	logic [DELAY_COUNT_WIDTH-1:0] cnt_q, cnt_d;
	logic [7:0]                  pre_q, pre_d;
	logic [7:0]                  byte_q, byte_d;
	logic                        is_data_q, is_data_d;
	logic                        low_q, low_d;
	lcd4_pkg::pins_t             pins;
	lcd4_pkg::pins_t             m_pins_q;
	logic                        m_valid_q;
	logic                        fire;
	logic                        done;
	logic                        ready;

	// delay timer
	logic [15:0]                  target_raw;
	logic [15:0]                  target;
	logic [7:0]                   cpm;
	logic [7:0]                   pre_inc;
	logic [DELAY_COUNT_WIDTH-1:0] cnt_inc;
	logic                         us_hit;
	logic                         tick_done;
	logic [7:0]                   tick_pre;
	logic [DELAY_COUNT_WIDTH-1:0] tick_cnt;
	logic [2:0]                   step_inc;

	assign q_ready  = !m_valid_q || m_tready;
	assign fire     = q_valid && q_ready;
	assign m_tvalid = m_valid_q;
	assign m_tdata  = {{lcd4_pkg::PINS_PAD_W{1'b0}}, m_pins_q};

	// config
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.cycles_per_us   <= lcd4_pkg::RST_CYCLES_PER_US;
			cfg_q.enable_phase_us <= lcd4_pkg::RST_ENABLE_PHASE;
			cfg_q.settle_us       <= lcd4_pkg::RST_SETTLE;
			cfg_q.power_on_us     <= lcd4_pkg::RST_POWER_ON;
			cfg_q.mode_switch_us  <= lcd4_pkg::RST_MODE_SWITCH;
		end else if (cfg_wr) begin
			case (cfg_index)
				lcd4_pkg::CFG_CYCLES_PER_US: cfg_q.cycles_per_us   <= cfg_data[7:0];
				lcd4_pkg::CFG_ENABLE_PHASE:  cfg_q.enable_phase_us <= cfg_data[9:0];
				lcd4_pkg::CFG_SETTLE:        cfg_q.settle_us       <= cfg_data[13:0];
				lcd4_pkg::CFG_POWER_ON:      cfg_q.power_on_us     <= cfg_data;
				lcd4_pkg::CFG_MODE_SWITCH:   cfg_q.mode_switch_us  <= cfg_data;
				default: ;
			endcase
		end
	end

	assign done  = (step_q >= lcd4_pkg::STEPS_DONE);
	assign ready = (phase_q == lcd4_pkg::PH_IDLE) && done;

	// pins from the current state
	always_comb begin
		pins.init_done       = done;
		pins.ready_res       = ready;
		pins.register_select = is_data_q;
		pins.read_write      = 1'b0;
		pins.enable_pin      = 1'b0;
		pins.data_nibble     = byte_q[3:0];
		pins.top_line_input  = 1'b0;
		unique case (phase_q) inside
			lcd4_pkg::PH_POLL: begin
				pins.register_select = 1'b0;
				pins.read_write      = 1'b1;
				pins.enable_pin      = 1'b1;
				pins.data_nibble     = 4'd0;
				pins.top_line_input  = 1'b1;
			end
			lcd4_pkg::PH_NIB_PRE, lcd4_pkg::PH_NIB_HIGH, lcd4_pkg::PH_NIB_POST: begin
				pins.enable_pin  = (phase_q == lcd4_pkg::PH_NIB_HIGH);
				pins.data_nibble = low_q ? byte_q[3:0] : byte_q[7:4];
			end
			default: ;
		endcase
	end

	// timer target by phase, zero reads as one
	always_comb begin
		unique case (phase_q)
			lcd4_pkg::PH_POWER: target_raw = cfg_q.power_on_us;
			lcd4_pkg::PH_WAIT:  target_raw = (step_q == 3'd0) ? cfg_q.mode_switch_us
				: {2'b00, cfg_q.settle_us};
			default:            target_raw = {6'd0, cfg_q.enable_phase_us};
		endcase
	end

	assign target    = (target_raw == 16'd0) ? 16'd1 : target_raw;
	assign cpm       = (cfg_q.cycles_per_us == 8'd0) ? 8'd1 : cfg_q.cycles_per_us;
	assign pre_inc   = pre_q + 8'd1;
	assign cnt_inc   = cnt_q + 1'b1;
	assign us_hit    = (pre_inc >= cpm);
	assign tick_done = us_hit && (cnt_inc >= DELAY_COUNT_WIDTH'(target));
	assign tick_pre  = us_hit ? 8'd0 : pre_inc;
	assign tick_cnt  = us_hit ? (tick_done ? '0 : cnt_inc) : cnt_q;
	assign step_inc  = step_q + 3'd1;

	// next state
	always_comb begin
		phase_d   = phase_q;
		step_d    = step_q;
		cnt_d     = cnt_q;
		pre_d     = pre_q;
		byte_d    = byte_q;
		is_data_d = is_data_q;
		low_d     = low_q;
		unique case (phase_q)
			lcd4_pkg::PH_POWER: begin
				cnt_d = tick_cnt;
				pre_d = tick_pre;
				if (tick_done) begin
					step_d    = 3'd0;
					byte_d    = lcd4_pkg::init_byte(3'd0);
					is_data_d = 1'b0;
					low_d     = 1'b1;
					phase_d   = lcd4_pkg::PH_NIB_PRE;
				end
			end
			lcd4_pkg::PH_NIB_PRE: begin
				cnt_d = tick_cnt;
				pre_d = tick_pre;
				if (tick_done) begin
					phase_d = lcd4_pkg::PH_NIB_HIGH;
				end
			end
			lcd4_pkg::PH_NIB_HIGH: begin
				cnt_d = tick_cnt;
				pre_d = tick_pre;
				if (tick_done) begin
					phase_d = lcd4_pkg::PH_NIB_POST;
				end
			end
			lcd4_pkg::PH_NIB_POST: begin
				cnt_d = tick_cnt;
				pre_d = tick_pre;
				if (tick_done) begin
					if (!low_q) begin
						low_d   = 1'b1;
						phase_d = lcd4_pkg::PH_NIB_PRE;
					end else begin
						phase_d = done ? lcd4_pkg::PH_IDLE : lcd4_pkg::PH_WAIT;
					end
				end
			end
			lcd4_pkg::PH_WAIT: begin
				cnt_d = tick_cnt;
				pre_d = tick_pre;
				if (tick_done) begin
					if (step_inc >= lcd4_pkg::STEPS_DONE) begin
						step_d  = lcd4_pkg::STEPS_DONE;
						phase_d = lcd4_pkg::PH_IDLE;
					end else begin
						step_d    = step_inc;
						byte_d    = lcd4_pkg::init_byte(step_inc);
						is_data_d = 1'b0;
						low_d     = 1'b0;
						phase_d   = lcd4_pkg::PH_NIB_PRE;
					end
				end
			end
			lcd4_pkg::PH_POLL: begin
				// busy released, start the high nibble
				if (!q_item.busy) begin
					phase_d = lcd4_pkg::PH_NIB_PRE;
					low_d   = 1'b0;
					cnt_d   = '0;
					pre_d   = 8'd0;
				end
			end
			default: begin
				if (ready && q_item.go) begin
					byte_d    = q_item.cmd_byte;
					is_data_d = q_item.is_data;
					low_d     = 1'b0;
					cnt_d     = '0;
					pre_d     = 8'd0;
					phase_d   = lcd4_pkg::PH_POLL;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= lcd4_pkg::PH_POWER;
			step_q    <= 3'd0;
			cnt_q     <= '0;
			pre_q     <= 8'd0;
			byte_q    <= 8'd0;
			is_data_q <= 1'b0;
			low_q     <= 1'b0;
		end else if (fire) begin
			phase_q   <= phase_d;
			step_q    <= step_d;
			cnt_q     <= cnt_d;
			pre_q     <= pre_d;
			byte_q    <= byte_d;
			is_data_q <= is_data_d;
			low_q     <= low_d;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (fire) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			m_pins_q <= pins;
		end
	end

`ifndef SYNTHESIS
	a_poll_after_init: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == lcd4_pkg::PH_POLL |-> step_q == lcd4_pkg::STEPS_DONE)
		else $error("busy poll before power-on sequence finished");

	a_step_range: assert property (@(posedge clk) disable iff (!arst_n)
		step_q <= lcd4_pkg::STEPS_DONE)
		else $error("init step out of range");

	a_hold_without_step: assert property (@(posedge clk) disable iff (!arst_n)
		!fire |=> $stable(phase_q) && $stable(step_q) && $stable(byte_q))
		else $error("sequencer state moved without a transaction");

	a_result_loaded: assert property (@(posedge clk) disable iff (!arst_n)
		fire |=> m_valid_q)
		else $error("processed transaction left no result");

	a_prescale_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pre_q != 8'hFF)
		else $error("cycle prescaler overran");
`endif

endmodule
